FILE: hw/rtl/pure_pursuit_steering_assert.svh
// ----------------------------------------------------------------------------
// pure_pursuit_steering_assert.svh
// Assertion macros for the steering block, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PURE_PURSUIT_STEERING_ASSERT_SVH
`define PURE_PURSUIT_STEERING_ASSERT_SVH
`ifndef SYNTH
`define PPS_ASSERT_IMP(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
		else $error("pps: implication check failed");
`define PPS_ASSERT_NXT(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
		else $error("pps: next-cycle check failed");
`else
`define PPS_ASSERT_IMP(lbl, ck, rn, a, b)
`define PPS_ASSERT_NXT(lbl, ck, rn, a, b)
`endif
`endif

FILE: hw/rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, constants and the arctangent table of the steering pipeline.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int DIV_BITS      = 33;
	localparam int NORM_STEPS    = 5;
	// P1 P2 P3, normalize, flip, vectoring, quantize, rotation, mult, round,
	// divide, final
	localparam int PIPE_DEPTH = 3 + NORM_STEPS + 1 + CORDIC_STAGES + 1
		+ CORDIC_STAGES + 1 + 1 + DIV_BITS + 1;

	localparam logic REG_SPEED     = 1'b0;
	localparam logic REG_LOOKAHEAD = 1'b1;

	typedef logic signed [39:0] vec_t;
	typedef logic signed [33:0] rot_t;
	typedef logic [33:0] mag_t;
	typedef logic [31:0] angle_t;
	typedef logic [4:0] step_t;

	localparam rot_t CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		vec_t x;
		vec_t y;
		mag_t m;
	} norm_t;

	typedef struct packed {
		vec_t   x;
		vec_t   y;
		angle_t z;
		logic   zero;
	} cvec_t;

	typedef struct packed {
		rot_t x;
		rot_t y;
		rot_t z;
	} crot_t;

	typedef struct packed {
		logic [23:0]         r;
		logic [DIV_BITS-1:0] nq;
		logic                neg;
		logic                ovf;
	} div_t;

	function automatic angle_t atan_step(input step_t i);
		angle_t a;
		case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			default: a = 32'h0;
		endcase
		return a;
	endfunction

endpackage

FILE: hw/rtl/pps_if.sv
// ----------------------------------------------------------------------------
// pps_if
// Valid/ready channels for pose beats in and steering beats out.
// ----------------------------------------------------------------------------
interface pps_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] robot_x;
	logic signed [31:0] robot_y;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;

	modport source(output valid, robot_x, robot_y, quat_x, quat_y, quat_z, quat_w,
		target_x, target_y, input ready);
	modport sink(input valid, robot_x, robot_y, quat_x, quat_y, quat_z, quat_w,
		target_x, target_y, output ready);
endinterface

interface pps_out_if;
	logic               valid;
	logic               ready;
	logic [23:0]        forward_velocity;
	logic signed [31:0] turn_rate;
	logic               rate_saturated;

	modport source(output valid, forward_velocity, turn_rate, rate_saturated,
		input ready);
	modport sink(input valid, forward_velocity, turn_rate, rate_saturated,
		output ready);
endinterface

FILE: hw/rtl/pps_norm_cell.sv
// ----------------------------------------------------------------------------
// pps_norm_cell
// One step of the left-shift normalization ahead of the vectoring CORDIC.
// ----------------------------------------------------------------------------
module pps_norm_cell (
	input  logic           clk,
	input  logic           en,
	input  logic [4:0]     sh,
	input  pps_pkg::norm_t d,
	output pps_pkg::norm_t q
);
	pps_pkg::mag_t thr;

	assign thr = pps_pkg::mag_t'(1) << (6'd32 - {1'b0, sh});

	always_ff @(posedge clk) begin
		if (en) begin
			// shift while the largest magnitude stays below bit 32
			if (d.m < thr) begin
				q.x <= d.x <<< sh;
				q.y <= d.y <<< sh;
				q.m <= d.m << sh;
			end else begin
				q <= d;
			end
		end
	end
endmodule

FILE: hw/rtl/pps_vec_cell.sv
// ----------------------------------------------------------------------------
// pps_vec_cell
// One vectoring CORDIC iteration, drives y toward zero and sums the angle.
// ----------------------------------------------------------------------------
module pps_vec_cell (
	input  logic           clk,
	input  logic           en,
	input  pps_pkg::step_t idx,
	input  pps_pkg::cvec_t d,
	output pps_pkg::cvec_t q
);
	pps_pkg::vec_t xs, ys;

	assign xs = d.x >>> idx;
	assign ys = d.y >>> idx;

	always_ff @(posedge clk) begin
		if (en) begin
			q.zero <= d.zero;
			if (!d.y[39]) begin
				q.x <= d.x + ys;
				q.y <= d.y - xs;
				q.z <= d.z + pps_pkg::atan_step(idx);
			end else begin
				q.x <= d.x - ys;
				q.y <= d.y + xs;
				q.z <= d.z - pps_pkg::atan_step(idx);
			end
		end
	end
endmodule

FILE: hw/rtl/pps_rot_cell.sv
// ----------------------------------------------------------------------------
// pps_rot_cell
// One rotation CORDIC iteration used for the sine of the heading error.
// ----------------------------------------------------------------------------
module pps_rot_cell (
	input  logic           clk,
	input  logic           en,
	input  pps_pkg::step_t idx,
	input  pps_pkg::crot_t d,
	output pps_pkg::crot_t q
);
	pps_pkg::rot_t xs, ys, at;

	assign xs = d.x >>> idx;
	assign ys = d.y >>> idx;
	assign at = pps_pkg::rot_t'({2'b00, pps_pkg::atan_step(idx)});

	always_ff @(posedge clk) begin
		if (en) begin
			if (!d.z[33]) begin
				q.x <= d.x - ys;
				q.y <= d.y + xs;
				q.z <= d.z - at;
			end else begin
				q.x <= d.x + ys;
				q.y <= d.y - xs;
				q.z <= d.z + at;
			end
		end
	end
endmodule

FILE: hw/rtl/pps_div_cell.sv
// ----------------------------------------------------------------------------
// pps_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module pps_div_cell (
	input  logic          clk,
	input  logic          en,
	input  logic [23:0]   divisor,
	input  pps_pkg::div_t d,
	output pps_pkg::div_t q
);
	logic [24:0] t;
	logic [24:0] diff;
	logic        take;

	assign t    = {d.r, d.nq[pps_pkg::DIV_BITS-1]};
	assign take = (t >= {1'b0, divisor});
	assign diff = t - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (en) begin
			q.r   <= take ? diff[23:0] : t[23:0];
			q.nq  <= {d.nq[pps_pkg::DIV_BITS-2:0], take};
			q.neg <= d.neg;
			q.ovf <= d.ovf;
		end
	end
endmodule

FILE: hw/rtl/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// Pure pursuit steering law: pose and target in, speed and turn rate out.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one pose/target beat (position, quaternion, target point),
//   rsp returns one steering beat per request beat, in order.
//   wr_en/wr_index/wr_data write the speed (0) and lookahead (1) registers;
//   write only while no beat is in flight.
//   Fully pipelined: one beat per cycle, PIPE_DEPTH = 78 register stages
//   (3 front-end, 5 normalize, 1 half-plane flip, 16 vectoring cells,
//   1 quantize, 16 rotation cells, multiply, round, 33 divider cells,
//   1 output register). Depth is set by the CORDIC cell rows and the
//   bit-per-cell divider. The whole pipeline advances together; when rsp
//   is stalled with a beat in the output register, req.ready drops and
//   everything holds.
//   Reset clears all valid bits and loads speed 0, lookahead 1.0 m.
// ----------------------------------------------------------------------------
`include "pure_pursuit_steering_assert.svh"

module pure_pursuit_steering (
	input  logic        clk,
	input  logic        arst_n,
	pps_in_if.sink      req,
	pps_out_if.source   rsp,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [23:0] wr_data
);
	localparam int NS = pps_pkg::CORDIC_STAGES;
	localparam int AB = pps_pkg::ANGLE_BITS;
	localparam int DB = pps_pkg::DIV_BITS;

	logic [23:0] speed_q, look_q, leff;
	logic        adv;
	logic [pps_pkg::PIPE_DEPTH-1:0] vld_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			look_q  <= 24'd65536;
		end else if (wr_en) begin
			case (wr_index)
				pps_pkg::REG_SPEED:     speed_q <= wr_data;
				pps_pkg::REG_LOOKAHEAD: look_q  <= wr_data;
				default: ;
			endcase
		end
	end

	assign leff = (look_q == '0) ? 24'd1 : look_q;

	assign adv       = !vld_q[pps_pkg::PIPE_DEPTH-1] || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = vld_q[pps_pkg::PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[pps_pkg::PIPE_DEPTH-2:0], req.valid};
		end
	end

	// stage 1: quaternion products and target offset
	logic signed [31:0] pwz_s1, pxy_s1, pyy_s1, pzz_s1;
	logic signed [32:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pwz_s1 <= req.quat_w * req.quat_z;
			pxy_s1 <= req.quat_x * req.quat_y;
			pyy_s1 <= req.quat_y * req.quat_y;
			pzz_s1 <= req.quat_z * req.quat_z;
			dx_s1  <= 33'(req.target_x) - 33'(req.robot_x);
			dy_s1  <= 33'(req.target_y) - 33'(req.robot_y);
		end
	end

	// stage 2: yaw numerator and denominator
	pps_pkg::vec_t ynum_s2, yden_s2, bx_s2, by_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ynum_s2 <= (pps_pkg::vec_t'(pwz_s1) + pps_pkg::vec_t'(pxy_s1)) <<< 1;
			yden_s2 <= pps_pkg::vec_t'(40'sd1073741824)
				- ((pps_pkg::vec_t'(pyy_s1) + pps_pkg::vec_t'(pzz_s1)) <<< 1);
			bx_s2   <= pps_pkg::vec_t'(dx_s1);
			by_s2   <= pps_pkg::vec_t'(dy_s1);
		end
	end

	// stage 3: larger magnitude of each vector
	function automatic pps_pkg::mag_t vmax(input pps_pkg::vec_t a, input pps_pkg::vec_t b);
		pps_pkg::vec_t aa, bb;
		aa = a[39] ? -a : a;
		bb = b[39] ? -b : b;
		return (aa > bb) ? aa[33:0] : bb[33:0];
	endfunction

	pps_pkg::norm_t yn [0:pps_pkg::NORM_STEPS];
	pps_pkg::norm_t bn [0:pps_pkg::NORM_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			yn[0] <= '{x: yden_s2, y: ynum_s2, m: vmax(yden_s2, ynum_s2)};
			bn[0] <= '{x: bx_s2, y: by_s2, m: vmax(bx_s2, by_s2)};
		end
	end

	for (genvar k = 0; k < pps_pkg::NORM_STEPS; k++) begin : g_norm
		pps_norm_cell u_yaw (.clk(clk), .en(adv), .sh(5'(16 >> k)),
			.d(yn[k]), .q(yn[k+1]));
		pps_norm_cell u_brg (.clk(clk), .en(adv), .sh(5'(16 >> k)),
			.d(bn[k]), .q(bn[k+1]));
	end

	// flip into the right half plane, note the zero vector
	function automatic pps_pkg::cvec_t flip(input pps_pkg::norm_t n);
		pps_pkg::cvec_t c;
		c.zero = (n.m == '0);
		if (n.x[39]) begin
			c.x = -n.x;
			c.y = -n.y;
			c.z = 32'h80000000;
		end else begin
			c.x = n.x;
			c.y = n.y;
			c.z = '0;
		end
		return c;
	endfunction

	pps_pkg::cvec_t yv [0:NS];
	pps_pkg::cvec_t bv [0:NS];

	always_ff @(posedge clk) begin
		if (adv) begin
			yv[0] <= flip(yn[pps_pkg::NORM_STEPS]);
			bv[0] <= flip(bn[pps_pkg::NORM_STEPS]);
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_vec
		pps_vec_cell u_yaw (.clk(clk), .en(adv), .idx(pps_pkg::step_t'(i)),
			.d(yv[i]), .q(yv[i+1]));
		pps_vec_cell u_brg (.clk(clk), .en(adv), .idx(pps_pkg::step_t'(i)),
			.d(bv[i]), .q(bv[i+1]));
	end

	// quantize both angles, heading error, fold into +-quarter turn
	function automatic logic [AB-1:0] quant(input pps_pkg::cvec_t c);
		pps_pkg::angle_t s;
		s = (c.zero ? 32'h0 : c.z) + (32'h1 << (31 - AB));
		return s[31 -: AB];
	endfunction

	logic [AB-1:0]      alpha;
	pps_pkg::angle_t    a32;
	pps_pkg::rot_t      zs, zf;

	always_comb begin
		alpha = quant(bv[NS]) - quant(yv[NS]);
		a32   = {alpha, {(32 - AB){1'b0}}};
		zs    = pps_pkg::rot_t'($signed(a32));
		if (zs > 34'sd1073741824) begin
			zf = 34'sd2147483648 - zs;
		end else if (zs < -34'sd1073741824) begin
			zf = -34'sd2147483648 - zs;
		end else begin
			zf = zs;
		end
	end

	pps_pkg::crot_t rv [0:NS];

	always_ff @(posedge clk) begin
		if (adv) begin
			rv[0] <= '{x: pps_pkg::CORDIC_GAIN, y: '0, z: zf};
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		pps_rot_cell u_rot (.clk(clk), .en(adv), .idx(pps_pkg::step_t'(i)),
			.d(rv[i]), .q(rv[i+1]));
	end

	// speed times sine
	logic signed [58:0] prod_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= $signed({1'b0, speed_q}) * rv[NS].y;
		end
	end

	// round half away: |p| + d/2, then drop the 2^13 factor of the divisor
	logic [58:0] pmag;
	logic [59:0] nsum;
	logic [46:0] np;

	assign pmag = prod_s1[58] ? 59'(-prod_s1) : 59'(prod_s1);
	assign nsum = {1'b0, pmag} + {24'd0, leff, 12'd0};
	assign np   = nsum[59:13];

	pps_pkg::div_t dv [0:DB];

	always_ff @(posedge clk) begin
		if (adv) begin
			dv[0].ovf <= ({10'd0, np[46:33]} >= leff);
			dv[0].r   <= {10'd0, np[46:33]};
			dv[0].nq  <= np[DB-1:0];
			dv[0].neg <= prod_s1[58];
		end
	end

	for (genvar i = 0; i < DB; i++) begin : g_div
		pps_div_cell u_div (.clk(clk), .en(adv), .divisor(leff),
			.d(dv[i]), .q(dv[i+1]));
	end

	// sign, saturation, output register
	logic [DB-1:0] qv;
	logic          sat;
	logic [31:0]   rate;

	always_comb begin
		qv = dv[DB].nq;
		if (dv[DB].neg) begin
			sat  = dv[DB].ovf || (qv > 33'h080000000);
			rate = sat ? 32'h80000000 : -qv[31:0];
		end else begin
			sat  = dv[DB].ovf || (qv > 33'h07FFFFFFF);
			rate = sat ? 32'h7FFFFFFF : qv[31:0];
		end
	end

	logic [23:0] fwd_q;
	logic [31:0] rate_q;
	logic        sat_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_q  <= speed_q;
			rate_q <= rate;
			sat_q  <= sat;
		end
	end

	assign rsp.forward_velocity = fwd_q;
	assign rsp.turn_rate        = rate_q;
	assign rsp.rate_saturated   = sat_q;

	`PPS_ASSERT_IMP(a_sat_clips, clk, arst_n, rsp.valid && rsp.rate_saturated,
		(rsp.turn_rate == 32'sh7FFFFFFF) || (rsp.turn_rate == 32'sh80000000))
	`PPS_ASSERT_IMP(a_ready_follows_out, clk, arst_n, 1'b1,
		req.ready == (!rsp.valid || rsp.ready))
	`PPS_ASSERT_NXT(a_stall_keeps_beat, clk, arst_n, rsp.valid && !rsp.ready,
		rsp.valid && $stable(rate_q) && $stable(sat_q))
endmodule

FILE: tb/tb_pure_pursuit_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pure_pursuit_steering
// Drives pose/target beats with random bursts and output stalls, predicts
// speed and turn rate with a bit-exact CORDIC/divide model, checks in order.
// ----------------------------------------------------------------------------
module tb_pure_pursuit_steering;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = pps_pkg::PIPE_DEPTH + 20;

	localparam bit [31:0] ATAN_TURNS [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

	typedef struct {
		logic signed [31:0] rx, ry, tx, ty;
		logic signed [15:0] qx, qy, qz, qw;
	} pose_t;

	typedef struct {
		logic [23:0]        speed;
		logic signed [31:0] rate;
		logic               sat;
	} steer_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic        wr_index;
	logic [23:0] wr_data;

	pps_in_if  req_if();
	pps_out_if rsp_if();

	pure_pursuit_steering i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if.sink),
		.rsp     (rsp_if.source),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	steer_t      steer_q[$];
	logic [23:0] speed_cfg;
	logic [23:0] look_cfg;
	int          errors = 0;
	int          burst_left;
	int          hold_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------- predictor ----------------
	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [31:0] heading_of(longint x, longint y);
		longint    m, nx, ny;
		logic [31:0] z;
		m = absl(x) > absl(y) ? absl(x) : absl(y);
		z = 32'h0;
		if (m == 0)
			return 32'h0;
		while (m < 64'sd2147483648) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h80000000;
		end
		for (int i = 0; i < pps_pkg::CORDIC_STAGES && i < 24; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + ATAN_TURNS[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - ATAN_TURNS[i];
			end
			x = nx;
			y = ny;
		end
		return z;
	endfunction

	function automatic longint sine_of(logic [31:0] a);
		longint z, x, y, nx, ny;
		z = longint'($signed(a));
		x = 652032874;
		y = 0;
		if (z > 64'sd1073741824)
			z = 64'sd2147483648 - z;
		else if (z < -64'sd1073741824)
			z = -64'sd2147483648 - z;
		for (int i = 0; i < pps_pkg::CORDIC_STAGES && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - longint'(ATAN_TURNS[i]);
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + longint'(ATAN_TURNS[i]);
			end
			x = nx;
			y = ny;
		end
		return y;
	endfunction

	function automatic logic [31:0] coarse_angle(logic [31:0] z);
		logic [31:0] r;
		r = (z + (32'd1 << (31 - pps_pkg::ANGLE_BITS))) >> (32 - pps_pkg::ANGLE_BITS);
		return r & ((32'd1 << pps_pkg::ANGLE_BITS) - 1);
	endfunction

	function automatic steer_t steer_predict(pose_t p);
		longint      num, den, s, prod, d, q;
		logic [31:0] yaw, bear, alpha;
		steer_t      r;
		num = 2 * (longint'(p.qw) * p.qz + longint'(p.qx) * p.qy);
		den = 64'sd1073741824 - 2 * (longint'(p.qy) * p.qy + longint'(p.qz) * p.qz);
		yaw = coarse_angle(heading_of(den, num));
		bear = coarse_angle(heading_of(longint'(p.tx) - longint'(p.rx),
			longint'(p.ty) - longint'(p.ry)));
		alpha = (bear - yaw) & ((32'd1 << pps_pkg::ANGLE_BITS) - 1);
		s = sine_of(alpha << (32 - pps_pkg::ANGLE_BITS));
		prod = longint'(speed_cfg) * s;
		d = longint'(look_cfg == 0 ? 24'd1 : look_cfg) * 8192;
		q = (absl(prod) + d / 2) / d;
		if (prod < 0)
			q = -q;
		r.speed = speed_cfg;
		r.sat = 1'b0;
		if (q > 64'sd2147483647) begin
			q = 64'sd2147483647;
			r.sat = 1'b1;
		end else if (q < -64'sd2147483648) begin
			q = -64'sd2147483648;
			r.sat = 1'b1;
		end
		r.rate = q[31:0];
		return r;
	endfunction

	// ---------------- drivers ----------------
	task automatic send_pose(pose_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_if.valid    <= 1'b1;
		req_if.robot_x  <= p.rx;
		req_if.robot_y  <= p.ry;
		req_if.quat_x   <= p.qx;
		req_if.quat_y   <= p.qy;
		req_if.quat_z   <= p.qz;
		req_if.quat_w   <= p.qw;
		req_if.target_x <= p.tx;
		req_if.target_y <= p.ty;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		steer_q.push_back(steer_predict(p));
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (steer_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [23:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == pps_pkg::REG_SPEED)
			speed_cfg = val;
		else
			look_cfg = val;
	endtask

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
			2: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
			default: return $signed($urandom_range(0, 2047)) - 1024;
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		p.rx = rand_pos();
		p.ry = rand_pos();
		p.qx = 16'($urandom);
		p.qy = 16'($urandom);
		p.qz = 16'($urandom);
		p.qw = 16'($urandom);
		case ($urandom_range(0, 5))
			0, 1: begin // planar heading only
				p.qx = 16'sd0;
				p.qy = 16'sd0;
			end
			2: begin // target near the robot
				p.tx = p.rx + $signed($urandom_range(0, 8191)) - 4096;
				p.ty = p.ry + $signed($urandom_range(0, 8191)) - 4096;
				return p;
			end
			3: begin
				if ($urandom_range(0, 9) == 0) begin
					p.tx = p.rx;
					p.ty = p.ry;
					return p;
				end
			end
			default: ;
		endcase
		p.tx = rand_pos();
		p.ty = rand_pos();
		return p;
	endfunction

	function automatic pose_t mk_pose(logic signed [31:0] rx, ry, tx, ty,
		logic signed [15:0] qx, qy, qz, qw);
		pose_t p;
		p.rx = rx; p.ry = ry; p.tx = tx; p.ty = ty;
		p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw;
		return p;
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed();
		localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
		localparam logic signed [31:0] PMIN = 32'sh80000000;
		localparam logic signed [15:0] QMAX = 16'sh7FFF;
		localparam logic signed [15:0] QMIN = 16'sh8000;
		write_reg(pps_pkg::REG_SPEED, 24'h010000);
		send_pose(mk_pose(0, 0, 32'sh10000, 0, 0, 0, 0, QMAX));
		send_pose(mk_pose(0, 0, 0, 32'sh10000, 0, 0, 0, QMAX));
		send_pose(mk_pose(0, 0, -32'sh10000, 0, 0, 0, 0, QMAX));
		send_pose(mk_pose(0, 0, 0, -32'sh10000, 0, 0, QMAX, 0));
		send_pose(mk_pose(5, 7, 5, 7, 0, 0, 0, 0));          // zero quat, same point
		send_pose(mk_pose(PMIN, PMIN, PMAX, PMAX, QMIN, QMIN, QMIN, QMIN));
		send_pose(mk_pose(PMAX, PMAX, PMIN, PMIN, QMAX, QMAX, QMAX, QMAX));
		send_pose(mk_pose(PMAX, PMIN, PMIN, PMAX, QMIN, QMAX, QMIN, QMAX));
		send_pose(mk_pose(0, 0, PMAX, 0, QMAX, 0, 0, 0));      // non-unit axis
		send_pose(mk_pose(0, 0, PMAX, 1, 0, QMAX, 0, 0));
		send_pose(mk_pose(0, 0, 1, 0, 0, 0, QMIN, QMAX));
		drain();
		write_reg(pps_pkg::REG_SPEED, 24'hFFFFFF);
		write_reg(pps_pkg::REG_LOOKAHEAD, 24'd1);              // saturates both ways
		send_pose(mk_pose(0, 0, 0, 32'sh10000, 0, 0, 0, QMAX));
		send_pose(mk_pose(0, 0, 0, -32'sh10000, 0, 0, 0, QMAX));
		send_pose(mk_pose(0, 0, 32'sh10000, 0, 0, 0, 0, QMAX));
		drain();
		write_reg(pps_pkg::REG_LOOKAHEAD, 24'd0);              // treated as one LSB
		send_pose(mk_pose(0, 0, 32'sh10000, 32'sh10000, 0, 0, 0, QMAX));
		send_pose(mk_pose(0, 0, -32'sh10000, -1, 0, 0, 0, QMAX));
		drain();
		write_reg(pps_pkg::REG_LOOKAHEAD, 24'hFFFFFF);
		send_pose(mk_pose(0, 0, 32'sh10000, 32'sh10000, 0, 0, 0, QMAX));
		send_pose(mk_pose(1, 1, 0, 0, 0, 0, QMAX, QMAX));
		drain();
	endtask

	task automatic test_random(logic [23:0] spd, logic [23:0] look, int n);
		write_reg(pps_pkg::REG_SPEED, spd);
		write_reg(pps_pkg::REG_LOOKAHEAD, look);
		repeat (n) send_pose(rand_pose());
		drain();
	endtask

	task automatic test_backpressure();
		write_reg(pps_pkg::REG_SPEED, 24'($urandom_range(0, 24'hFFFFFF)));
		hold_cycles = 400;
		repeat (150) send_pose(rand_pose());
		drain();
	endtask

	// ---------------- receiver ----------------
	initial begin
		int mode, left;
		mode = 0;
		left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_if.ready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(50, 300);
				end
				left--;
				case (mode)
					0: rsp_if.ready <= 1'b1;
					1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_if.ready <= ($urandom_range(0, 7) == 0);
					default: rsp_if.ready <= (left % 6) < 3;
				endcase
			end
		end
	end

	// ---------------- checker ----------------
	always @(posedge clk) begin
		steer_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (steer_q.size() == 0) begin
				$display("%0t: unexpected beat speed=%h rate=%h sat=%b", $time,
					rsp_if.forward_velocity, rsp_if.turn_rate, rsp_if.rate_saturated);
				errors++;
			end else begin
				e = steer_q.pop_front();
				if (rsp_if.forward_velocity !== e.speed) begin
					$display("%0t: forward_velocity exp %h got %h", $time, e.speed,
						rsp_if.forward_velocity);
					errors++;
				end
				if (rsp_if.turn_rate !== e.rate) begin
					$display("%0t: turn_rate exp %0d got %0d", $time, e.rate,
						rsp_if.turn_rate);
					errors++;
				end
				if (rsp_if.rate_saturated !== e.sat) begin
					$display("%0t: rate_saturated exp %b got %b", $time, e.sat,
						rsp_if.rate_saturated);
					errors++;
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ---------------- main ----------------
	initial begin
		burst_left = 0;
		hold_cycles = 0;
		speed_cfg = 24'd0;
		look_cfg = 24'd65536;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = 1'b0;
		wr_data = 24'd0;
		req_if.valid = 1'b0;
		req_if.robot_x = '0;
		req_if.robot_y = '0;
		req_if.quat_x = '0;
		req_if.quat_y = '0;
		req_if.quat_z = '0;
		req_if.quat_w = '0;
		req_if.target_x = '0;
		req_if.target_y = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_random(24'd0, 24'd65536, 60);                     // reset settings
		test_directed();
		test_random(24'h018000, 24'h020000, 300);
		test_random(24'hFFFFFF, 24'hFFFFFF, 200);
		test_random(24'hFFFFFF, 24'd1, 150);
		test_random(24'($urandom_range(0, 24'hFFFFFF)),
			24'($urandom_range(1, 24'hFFFFFF)), 250);
		test_random(24'($urandom_range(0, 24'h0FFFFF)),
			24'($urandom_range(1, 24'h00FFFF)), 200);
		test_backpressure();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
